// ----- rtl/sfd_pkg.sv -----
// Shared constants and types for the SBUS frame decoder.
`timescale 1ns / 1ps
package sfd_pkg;
  localparam int unsigned FRAME_LEN   = 25;
  localparam int unsigned PAYLOAD_LEN = 22;
  localparam int unsigned NUM_CH      = 16;
  localparam int unsigned CH_W        = 11;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned PAYLOAD_W   = PAYLOAD_LEN * 8;
  localparam int unsigned OUT_W       = 16;

  localparam logic [7:0] HEADER_BYTE = 8'h0F;

  localparam logic [POS_W-1:0] POS_IDLE    = POS_W'(0);
  localparam logic [POS_W-1:0] POS_LAST_PL = POS_W'(PAYLOAD_LEN);
  localparam logic [POS_W-1:0] POS_END     = POS_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] LAST_CH     = IDX_W'(NUM_CH - 1);

  typedef logic [PAYLOAD_W-1:0] payload_t;
endpackage

// ----- rtl/sfd_front.sv -----
// Front end: header hunt, frame position tracking and payload assembly.
`timescale 1ns / 1ps
module sfd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_ready,
  input  logic [7:0]       rx_byte,
  output logic             frame_valid,
  input  logic             frame_ready,
  output sfd_pkg::payload_t frame_data
);
  import sfd_pkg::*;

  logic [POS_W-1:0] pos;
  payload_t         payload;
  logic             accept;

  // only the final byte of a frame needs room in the queue
  assign byte_ready  = !(pos == POS_END && !frame_ready);
  assign accept      = byte_valid && byte_ready;
  assign frame_valid = byte_valid && pos == POS_END;
  assign frame_data  = payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_IDLE;
    end else if (accept) begin
      if (pos == POS_IDLE) begin
        if (rx_byte == HEADER_BYTE) pos <= POS_W'(1);
      end else if (pos == POS_END) begin
        pos <= POS_IDLE;
      end else begin
        pos <= pos + POS_W'(1);
      end
    end
  end

  // first payload byte ends up in the lowest bits after 22 shifts
  always_ff @(posedge clk) begin
    if (accept && pos != POS_IDLE && pos <= POS_LAST_PL) begin
      payload <= {rx_byte, payload[PAYLOAD_W-1:8]};
    end
  end
endmodule

// ----- rtl/sfd_queue.sv -----
// Two-entry frame queue between front and back end.
`timescale 1ns / 1ps
module sfd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sfd_pkg::payload_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sfd_pkg::payload_t out_data
);
  import sfd_pkg::*;

  payload_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
  end
endmodule

// ----- rtl/sfd_back.sv -----
// Back end: unpacks one queued frame into sixteen 11-bit channel transfers.
`timescale 1ns / 1ps
module sfd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          frame_valid,
  output logic                          frame_ready,
  input  sfd_pkg::payload_t             frame_data,
  output logic                          ch_valid,
  input  logic                          ch_ready,
  output logic [sfd_pkg::IDX_W-1:0]     ch_index,
  output logic [sfd_pkg::CH_W-1:0]      ch_value,
  output logic                          ch_last
);
  import sfd_pkg::*;

  logic             busy;
  logic [IDX_W-1:0] cnt;
  payload_t         data;
  logic             done;

  assign done        = busy && ch_ready && cnt == LAST_CH;
  assign frame_ready = !busy || done;
  assign ch_valid    = busy;
  assign ch_index    = cnt;
  assign ch_value    = data[CH_W-1:0];
  assign ch_last     = cnt == LAST_CH;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (frame_valid && frame_ready) begin
      busy <= 1'b1;
      cnt  <= '0;
      data <= frame_data;
    end else if (busy && ch_ready) begin
      if (cnt == LAST_CH) begin
        busy <= 1'b0;
      end else begin
        cnt  <= cnt + IDX_W'(1);
        data <= data >> CH_W;
      end
    end
  end
endmodule

// ----- rtl/sbus_frame_decoder.sv -----
// Top level of the SBUS frame decoder.
// Takes one byte per cycle; s_tready drops only on the last byte of a frame while the
// two-entry frame queue is full.
// A frame's first channel can transfer once the frame has passed the queue and the
// back-end load; 16 channel transfers follow, one per cycle while m_tready is high.
// Synchronous active-high reset returns to header hunt with an empty queue.
`timescale 1ns / 1ps
module sbus_frame_decoder (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,  // [7:0] rx_byte
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [sfd_pkg::OUT_W-1:0] m_tdata,  // [3:0] channel_index, [14:4] channel_value,
                                              // [15] zero
  output logic                      m_tlast   // last_channel
);
  import sfd_pkg::*;

  logic             fq_valid;
  logic             fq_ready;
  payload_t         fq_data;
  logic             qb_valid;
  logic             qb_ready;
  payload_t         qb_data;
  logic [IDX_W-1:0] ch_index;
  logic [CH_W-1:0]  ch_value;

  sfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (s_tvalid),
    .byte_ready  (s_tready),
    .rx_byte     (s_tdata),
    .frame_valid (fq_valid),
    .frame_ready (fq_ready),
    .frame_data  (fq_data)
  );

  sfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  sfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (qb_valid),
    .frame_ready (qb_ready),
    .frame_data  (qb_data),
    .ch_valid    (m_tvalid),
    .ch_ready    (m_tready),
    .ch_index    (ch_index),
    .ch_value    (ch_value),
    .ch_last     (m_tlast)
  );

  assign m_tdata = {1'b0, ch_value, ch_index};
endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the SBUS frame decoder.
`timescale 1ns / 1ps
module testbench;
  import sfd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PREDICTED   = -1;
  localparam int DRAIN_WAIT  = 24;

  typedef struct {
    logic [IDX_W-1:0] index;
    logic [CH_W-1:0]  value;
    logic             last;
  } channel_t;

  typedef struct {
    logic [7:0] data;
    int         all_ch;  // value every channel must carry, or PREDICTED
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tlast;

  sbus_frame_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Predictor state
  logic [POS_W-1:0] frame_pos = POS_IDLE;
  logic [7:0]       payload_bytes [PAYLOAD_LEN];
  channel_t         decoded_ch [NUM_CH];
  channel_t         pending_channels [$];

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int cycles = 0;
  int bytes_sent = 0;
  int frames_done = 0;
  int channels_checked = 0;

  // Header hunt, then 24 more bytes; 22 payload bytes kept, flags and end ignored.
  function automatic bit decode_rx_byte(input logic [7:0] b);
    payload_t flat;
    if (frame_pos == POS_IDLE) begin
      if (b == HEADER_BYTE) frame_pos = POS_IDLE + 1'b1;
      return 1'b0;
    end
    if (frame_pos <= POS_LAST_PL) payload_bytes[frame_pos - POS_W'(1)] = b;
    if (frame_pos != POS_END) begin
      frame_pos = frame_pos + 1'b1;
      return 1'b0;
    end
    frame_pos = POS_IDLE;
    for (int i = 0; i < PAYLOAD_LEN; i++) flat[8*i +: 8] = payload_bytes[i];
    for (int k = 0; k < NUM_CH; k++) begin
      decoded_ch[k].index = IDX_W'(k);
      decoded_ch[k].value = flat[CH_W*k +: CH_W];
      decoded_ch[k].last  = (IDX_W'(k) == LAST_CH);
    end
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input int all_ch);
    channel_t c;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    if (decode_rx_byte(b)) begin
      frames_done++;
      for (int k = 0; k < NUM_CH; k++) begin
        c = decoded_ch[k];
        if (all_ch != PREDICTED) begin
          c.index = IDX_W'(k);
          c.value = CH_W'(all_ch);
          c.last  = (k == NUM_CH - 1);
        end
        pending_channels.push_back(c);
      end
    end
  endtask

  // Noise at header hunt, then a full frame with patterned or random content.
  task automatic send_frame();
    logic [7:0] b;
    int mode;
    mode = $urandom_range(0, 9);
    repeat ($urandom_range(0, 3)) begin
      b = 8'($urandom_range(0, 255));
      if (b == HEADER_BYTE) b = ~HEADER_BYTE;
      send_byte(b, PREDICTED);
    end
    send_byte(HEADER_BYTE, PREDICTED);
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      case (mode)
        0: b = 8'h00;
        1: b = 8'hFF;
        2: b = ($urandom_range(0, 2) == 0) ? HEADER_BYTE : 8'($urandom_range(0, 255));
        3: b = (i % 2) ? 8'hAA : 8'h55;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b, PREDICTED);
    end
    send_byte(8'($urandom_range(0, 255)), PREDICTED);
    send_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)), PREDICTED);
  endtask

  // Dropped bytes at header hunt, then a frame of all-ones payload with a header
  // value as flags and a wrong end byte.
  stim_row_t directed_rows [] = '{
    '{8'h00, PREDICTED}, '{8'hFF, PREDICTED}, '{8'h0E, PREDICTED}, '{8'h10, PREDICTED},
    '{HEADER_BYTE, PREDICTED},
    '{8'hFF, PREDICTED}, '{8'hFF, PREDICTED}, '{8'hFF, PREDICTED}, '{8'hFF, PREDICTED},
    '{8'hFF, PREDICTED}, '{8'hFF, PREDICTED}, '{8'hFF, PREDICTED}, '{8'hFF, PREDICTED},
    '{8'hFF, PREDICTED}, '{8'hFF, PREDICTED}, '{8'hFF, PREDICTED}, '{8'hFF, PREDICTED},
    '{8'hFF, PREDICTED}, '{8'hFF, PREDICTED}, '{8'hFF, PREDICTED}, '{8'hFF, PREDICTED},
    '{8'hFF, PREDICTED}, '{8'hFF, PREDICTED}, '{8'hFF, PREDICTED}, '{8'hFF, PREDICTED},
    '{8'hFF, PREDICTED}, '{8'hFF, PREDICTED},
    '{HEADER_BYTE, PREDICTED}, '{8'hFF, 2047}
  };

  int phase_gap   [4] = '{0, 52, 0, 37};
  int phase_stall [4] = '{0, 0, 52, 37};
  int phase_frames[4] = '{2, 2, 3, 2};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    channel_t want;
    if (!rst && m_tvalid && m_tready) begin
      channels_checked++;
      if (pending_channels.size() == 0) begin
        $error("unexpected channel transfer: index %0d value %0d",
               m_tdata[3:0], m_tdata[14:4]);
        errors++;
      end else begin
        want = pending_channels.pop_front();
        if (m_tdata[3:0] !== want.index) begin
          $error("channel_index: expected %0d, got %0d", want.index, m_tdata[3:0]);
          errors++;
        end
        if (m_tdata[14:4] !== want.value) begin
          $error("channel_value: expected %0d, got %0d", want.value, m_tdata[14:4]);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last_channel: expected %0d, got %0d", want.last, m_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    m_tready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) send_byte(directed_rows[i].data, directed_rows[i].all_ch);

    for (int p = 0; p < 4; p++) begin
      send_gap_pct   = phase_gap[p];
      recv_stall_pct = phase_stall[p];
      repeat (phase_frames[p]) send_frame();
    end
    s_tvalid <= 1'b0;

    while (pending_channels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d bytes forming %0d frames; %0d channel transfers checked",
             bytes_sent, frames_done, channels_checked);
    $display("Idle mixes: none, sender gaps, receiver stalls, both");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
